// ===== design/rlesd_pkg.sv =====
package rlesd_pkg;

  // Header layout: four signature bytes, then four size bytes, LSB first.
  localparam int unsigned SIG_LEN    = 4;
  localparam int unsigned HEADER_LEN = 8;

  // Signature "RLE1", indexed by header position.
  localparam logic [7:0] SIGNATURE [SIG_LEN] = '{8'h52, 8'h4C, 8'h45, 8'h31};

  // Reset value of the escape byte register.
  localparam logic [7:0] ESCAPE_RESET = 8'hFF;

  // Default queue depths.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SIG   = 2'd1;
  localparam logic [1:0] STATUS_SIZE_ERR = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } rlesd_in_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] run_length;
    logic       done_res;
    logic [1:0] status;
  } rlesd_out_t;

  // Commands from the classifier to the run executor.
  typedef enum logic [1:0] {
    CMD_SIZE,   // one expected-size byte
    CMD_FAIL,   // end the file with a missing-signature status
    CMD_RUN     // one run, possibly empty when it closes the file
  } rlesd_cmd_kind_e;

  typedef struct packed {
    rlesd_cmd_kind_e kind;
    logic [7:0]      data;
    logic [7:0]      len;
    logic            last;
  } rlesd_cmd_t;

endpackage

// ===== design/rlesd_fifo.sv =====
module rlesd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // Status and handshake qualification.
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage array, no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill count never exceeds the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo count exceeds depth");

  // A lone push raises the count by one.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fifo count did not follow a push");

  // Read and write pointers meet only when empty or full.
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) |-> (empty_o || full_o))
    else $error("fifo pointers disagree with count");

endmodule

// ===== design/rlesd_front.sv =====
module rlesd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            escape_byte_i,
  input  logic                  accept_i,
  input  rlesd_pkg::rlesd_in_t  in_i,
  output logic                  cmd_push_o,
  output rlesd_pkg::rlesd_cmd_t cmd_o
);

  import rlesd_pkg::*;

  logic [3:0] hdr_idx_q, hdr_idx_d;
  logic       sig_bad_q, sig_bad_d;
  logic       discard_q, discard_d;
  logic       esc_pend_q, esc_pend_d;
  logic [7:0] pend_cnt_q, pend_cnt_d;

  logic [3:0] idx_next;
  logic       bad_next;
  logic [7:0] run_val;
  logic [7:0] run_len;

  // Classify each accepted byte and update the parse state.
  always_comb begin
    hdr_idx_d  = hdr_idx_q;
    sig_bad_d  = sig_bad_q;
    discard_d  = discard_q;
    esc_pend_d = esc_pend_q;
    pend_cnt_d = pend_cnt_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_RUN, data: in_i.in_byte, len: 8'd0, last: in_i.last};
    idx_next   = hdr_idx_q + 4'd1;
    bad_next   = sig_bad_q;
    run_val    = 8'd0;
    run_len    = 8'd0;

    if (hdr_idx_q < 4'(SIG_LEN) && in_i.in_byte != SIGNATURE[hdr_idx_q[1:0]]) begin
      bad_next = 1'b1;
    end

    if (accept_i) begin
      if (discard_q) begin
        // Drop bytes until the end of the file.
        if (in_i.last) begin
          hdr_idx_d  = '0;
          sig_bad_d  = 1'b0;
          discard_d  = 1'b0;
          esc_pend_d = 1'b0;
          pend_cnt_d = '0;
        end
      end else if (hdr_idx_q < 4'(HEADER_LEN)) begin
        if (idx_next == 4'(SIG_LEN) && bad_next) begin
          // Signature check failed on its fourth byte.
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_FAIL;
          hdr_idx_d  = in_i.last ? 4'd0 : idx_next;
          sig_bad_d  = 1'b0;
          discard_d  = !in_i.last;
        end else if (in_i.last) begin
          // File ends inside the header, or right after it.
          cmd_push_o = 1'b1;
          cmd_o.kind = (idx_next < 4'(HEADER_LEN)) ? CMD_FAIL : CMD_SIZE;
          hdr_idx_d  = '0;
          sig_bad_d  = 1'b0;
        end else begin
          cmd_push_o = (hdr_idx_q >= 4'(SIG_LEN));
          cmd_o.kind = CMD_SIZE;
          hdr_idx_d  = idx_next;
          sig_bad_d  = bad_next;
        end
      end else begin
        // Body: escape sequence decoding.
        if (pend_cnt_q != 8'd0) begin
          run_val    = in_i.in_byte;
          run_len    = pend_cnt_q;
          pend_cnt_d = '0;
          esc_pend_d = 1'b0;
        end else if (esc_pend_q) begin
          pend_cnt_d = in_i.in_byte;
        end else if (in_i.in_byte == escape_byte_i) begin
          esc_pend_d = 1'b1;
        end else begin
          run_val = in_i.in_byte;
          run_len = 8'd1;
        end
        cmd_o.data = run_val;
        cmd_o.len  = run_len;
        cmd_push_o = in_i.last || (run_len != 8'd0);
        if (in_i.last) begin
          hdr_idx_d  = '0;
          sig_bad_d  = 1'b0;
          esc_pend_d = 1'b0;
          pend_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q  <= '0;
      sig_bad_q  <= 1'b0;
      discard_q  <= 1'b0;
      esc_pend_q <= 1'b0;
      pend_cnt_q <= '0;
    end else begin
      hdr_idx_q  <= hdr_idx_d;
      sig_bad_q  <= sig_bad_d;
      discard_q  <= discard_d;
      esc_pend_q <= esc_pend_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  // Discarding only starts right after the signature.
  a_discard_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> (hdr_idx_q == 4'(SIG_LEN)))
    else $error("discarding outside the signature position");

  // A waiting count always belongs to an open escape.
  a_pend_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q != 8'd0) |-> esc_pend_q)
    else $error("count pending without escape");

  // Escape decoding only happens in the body.
  a_esc_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_pend_q |-> (hdr_idx_q == 4'(HEADER_LEN)))
    else $error("escape pending inside header");

endmodule

// ===== design/rlesd_back.sv =====
module rlesd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  rlesd_pkg::rlesd_cmd_t cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output rlesd_pkg::rlesd_out_t res_o
);

  import rlesd_pkg::*;

  logic [31:0] exp_size_q, exp_size_d;
  logic [31:0] out_cnt_q, out_cnt_d;
  logic [31:0] exp_shift;
  logic [31:0] cnt_sum;

  assign cmd_pop_o = cmd_valid_i && !res_full_i;
  // Size bytes arrive LSB first, so shifting in from the top lands them in place.
  assign exp_shift = {cmd_i.data, exp_size_q[31:8]};
  assign cnt_sum   = out_cnt_q + 32'(cmd_i.len);

  // Execute one command per cycle while the result queue has room, and form its result.
  always_comb begin
    exp_size_d = exp_size_q;
    out_cnt_d  = out_cnt_q;
    res_push_o = 1'b0;
    res_o      = '{out_byte: 8'd0, run_length: 8'd0, done_res: 1'b0,
                   status: STATUS_OK};
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        CMD_SIZE: begin
          exp_size_d = exp_shift;
          if (cmd_i.last) begin
            res_push_o     = 1'b1;
            res_o.done_res = 1'b1;
            res_o.status   = (out_cnt_q == exp_shift) ? STATUS_OK : STATUS_SIZE_ERR;
            exp_size_d     = '0;
            out_cnt_d      = '0;
          end
        end
        CMD_FAIL: begin
          res_push_o     = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = STATUS_NO_SIG;
          exp_size_d     = '0;
          out_cnt_d      = '0;
        end
        CMD_RUN: begin
          res_push_o       = 1'b1;
          res_o.out_byte   = cmd_i.data;
          res_o.run_length = cmd_i.len;
          out_cnt_d        = cnt_sum;
          if (cmd_i.last) begin
            res_o.done_res = 1'b1;
            res_o.status   = (cnt_sum == exp_size_q) ? STATUS_OK : STATUS_SIZE_ERR;
            exp_size_d     = '0;
            out_cnt_d      = '0;
          end
        end
        default: begin
          res_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      exp_size_q <= exp_size_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  // A result that does not end the file always carries data and no status.
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && !res_o.done_res) |-> (res_o.run_length != 8'd0 &&
                                         res_o.status == STATUS_OK))
    else $error("empty or flagged mid-file result");

  // The reserved status code is never produced.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.status != 2'd3))
    else $error("reserved status code");

  // Ending a file clears the output count.
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.done_res) |=> (out_cnt_q == 32'd0))
    else $error("output count not cleared after done");

endmodule

// ===== design/rle_escape_stream_decoder.sv =====
// Escape-byte run-length decoder for "RLE1" files. Bytes enter through a queue-style port
// (push/full) with a last flag on the final byte of each file; run descriptors leave through
// a second queue (empty/pop), each giving a byte value and a run length, plus a done flag and
// status on the transaction that ends the file (ok, missing signature, size mismatch). The
// block takes one byte per cycle when the result side keeps up. A classifier tracks the
// header and escape state and writes commands into a small queue; an executor keeps the
// 32-bit output count and the expected size, whose add and compare set the cycle time, and
// writes results into the output queue. Accepted bytes are classified combinationally; any
// command formed is queued, and its result is queued in turn. The escape byte register
// (reset 0xFF) must only be written while no file is in flight.
module rle_escape_stream_decoder #(
  parameter int unsigned CmdDepth = rlesd_pkg::CMD_DEPTH,
  parameter int unsigned ResDepth = rlesd_pkg::RES_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 push,
  input  rlesd_pkg::rlesd_in_t in_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output rlesd_pkg::rlesd_out_t out_o
);

  import rlesd_pkg::*;

  logic [7:0] escape_byte_q;
  logic       accept;
  logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
  rlesd_cmd_t cmd_in, cmd_out;
  logic       res_push, res_full;
  rlesd_out_t res_in;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_byte_q <= ESCAPE_RESET;
    end else if (cfg_we_i) begin
      escape_byte_q <= cfg_wdata_i;
    end
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Front end: header check and escape classification.
  rlesd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .escape_byte_i(escape_byte_q),
    .accept_i     (accept),
    .in_i         (in_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // Command queue between the two halves.
  rlesd_fifo #(
    .Width($bits(rlesd_cmd_t)),
    .Depth(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // Back end: counting, size check and result formation.
  rlesd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue toward the consumer.
  rlesd_fifo #(
    .Width($bits(rlesd_out_t)),
    .Depth(ResDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_o),
    .empty_o(empty)
  );

endmodule
